### design/s5rp_pkg.sv
// ----------------------------------------------------------------------------
// s5rp_pkg
// Types and constants shared by the SOCKS5 request parser.
// ----------------------------------------------------------------------------
package s5rp_pkg;

   localparam int ADDR_BYTES_DEFAULT = 256;
   localparam int COUNT_WIDTH        = 9;

   localparam logic [7:0] VERSION_BYTE  = 8'h05;
   localparam logic [7:0] CMD_CONNECT   = 8'h01;
   localparam logic [7:0] RSV_BYTE      = 8'h00;
   localparam logic [7:0] ATYP_IPV4     = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
   localparam logic [7:0] ATYP_IPV6     = 8'h04;
   localparam logic [7:0] V4_ADDR_BYTES = 8'd4;
   localparam logic [7:0] V6_ADDR_BYTES = 8'd16;
   localparam logic [COUNT_WIDTH-1:0] PORT_BYTES = COUNT_WIDTH'(2);

   localparam logic [1:0] STATUS_MORE  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   typedef enum logic [2:0] {
      PH_VERSION,
      PH_COMMAND,
      PH_RSV,
      PH_ATYP,
      PH_ADDR,
      PH_PORT,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_IPV4,
      KIND_DOMAIN,
      KIND_IPV6
   } kind_type;

   typedef struct packed {
      phase_type              phase;
      kind_type               kind;
      logic [7:0]             length;
      logic [COUNT_WIDTH-1:0] byte_count;
      logic [15:0]            port_accum;
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        addr_byte_valid;
      logic [7:0]  addr_byte;
      logic [7:0]  addr_index;
      kind_type    addr_kind;
      logic [7:0]  addr_length;
      logic [15:0] dest_port;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:      PH_VERSION,
      kind:       KIND_NONE,
      length:     8'd0,
      byte_count: '0,
      port_accum: 16'd0
   };

endpackage

### design/s5rp_step.sv
// ----------------------------------------------------------------------------
// s5rp_step
// Next-state and result logic for one request byte.
// ----------------------------------------------------------------------------
module s5rp_step
   import s5rp_pkg::*;
#(
   parameter int ADDR_BYTES = ADDR_BYTES_DEFAULT
) (
   input  state_type  state_i,
   input  logic [7:0] data_i,
   input  logic       restart_i,
   output state_type  state_o,
   output result_type result_o
);

   localparam logic [COUNT_WIDTH-1:0] ADDR_LIMIT = COUNT_WIDTH'(ADDR_BYTES);

   state_type              cur;
   state_type              nxt;
   logic                   dom;
   logic [COUNT_WIDTH-1:0] idx;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [COUNT_WIDTH-1:0] addr_end;
   logic                   store;

   always_comb begin
      cur = restart_i ? STATE_RESET : state_i;
   end

   assign dom      = (cur.kind == KIND_DOMAIN);
   assign idx      = cur.byte_count - COUNT_WIDTH'(dom);
   assign cnt_inc  = cur.byte_count + COUNT_WIDTH'(1);
   assign addr_end = COUNT_WIDTH'(cur.length) + COUNT_WIDTH'(dom);

   always_comb begin
      nxt   = cur;
      store = 1'b0;
      case (cur.phase)
         PH_VERSION: begin
            nxt.phase = (data_i == VERSION_BYTE) ? PH_COMMAND : PH_ERROR;
         end
         PH_COMMAND: begin
            nxt.phase = (data_i == CMD_CONNECT) ? PH_RSV : PH_ERROR;
         end
         PH_RSV: begin
            nxt.phase = (data_i == RSV_BYTE) ? PH_ATYP : PH_ERROR;
         end
         PH_ATYP: begin
            nxt.byte_count = '0;
            case (data_i)
               ATYP_IPV4: begin
                  nxt.kind   = KIND_IPV4;
                  nxt.length = V4_ADDR_BYTES;
                  nxt.phase  = PH_ADDR;
               end
               ATYP_IPV6: begin
                  nxt.kind   = KIND_IPV6;
                  nxt.length = V6_ADDR_BYTES;
                  nxt.phase  = PH_ADDR;
               end
               ATYP_DOMAIN: begin
                  nxt.kind  = KIND_DOMAIN;
                  nxt.phase = PH_ADDR;
               end
               default: begin
                  nxt.phase = PH_ERROR;
               end
            endcase
         end
         PH_ADDR: begin
            if (dom && cur.byte_count == '0) begin
               // domain length byte; zero length can never finish
               nxt.length     = data_i;
               nxt.byte_count = COUNT_WIDTH'(1);
               if (data_i == 8'd0) begin
                  nxt.phase = PH_ERROR;
               end
            end else if (idx >= ADDR_LIMIT) begin
               nxt.phase = PH_ERROR;
            end else begin
               store          = 1'b1;
               nxt.byte_count = cnt_inc;
               if (cnt_inc == addr_end) begin
                  nxt.byte_count = '0;
                  nxt.phase      = PH_PORT;
               end
            end
         end
         PH_PORT: begin
            nxt.port_accum = {cur.port_accum[7:0], data_i};
            nxt.byte_count = cnt_inc;
            if (cnt_inc == PORT_BYTES) begin
               nxt.byte_count = '0;
               nxt.phase      = PH_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (nxt.phase)
         PH_DONE:  result_o.status = STATUS_DONE;
         PH_ERROR: result_o.status = STATUS_ERROR;
         default:  result_o.status = STATUS_MORE;
      endcase
      result_o.addr_byte_valid = store;
      result_o.addr_byte       = store ? data_i : 8'd0;
      result_o.addr_index      = store ? idx[7:0] : 8'd0;
      result_o.addr_kind       = nxt.kind;
      result_o.addr_length     = nxt.length;
      result_o.dest_port       = nxt.port_accum;
   end

   assign state_o = nxt;

endmodule

### design/socks5_request_parser_top.sv
// ----------------------------------------------------------------------------
// socks5_request_parser_top
// SOCKS5 request parser: checks version, command and reserved byte, reads the
// address type, echoes address bytes with their index, gathers the port.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  data_byte, restart
//   rsp      out        rsp_valid / rsp_stall  status, address echo, port
//
// One byte per cycle while rsp_stall is low.
// Input register feeds the parser step; the parser state and the result
// register update together when the input word moves to the output.
// req_stall rises only while an input word waits behind a stalled result.
// Reset (synchronous) returns the parser to the version phase.
// ----------------------------------------------------------------------------
module socks5_request_parser_top
   import s5rp_pkg::*;
#(
   parameter int ADDR_BYTES = ADDR_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_addr_byte_valid,
   output logic [7:0]  rsp_addr_byte,
   output logic [7:0]  rsp_addr_index,
   output logic [1:0]  rsp_addr_kind,
   output logic [7:0]  rsp_addr_length,
   output logic [15:0] rsp_dest_port
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] data_ff;
   logic       restart_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       out_free;
   logic       advance;
   logic       accept;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   s5rp_step #(
      .ADDR_BYTES(ADDR_BYTES)
   ) u_step (
      .state_i  (state_ff),
      .data_i   (data_ff),
      .restart_i(restart_ff),
      .state_o  (state_in),
      .result_o (result_in)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff    <= req_data_byte;
         restart_ff <= req_restart;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = result_ff.status;
   assign rsp_addr_byte_valid = result_ff.addr_byte_valid;
   assign rsp_addr_byte       = result_ff.addr_byte;
   assign rsp_addr_index      = result_ff.addr_index;
   assign rsp_addr_kind       = result_ff.addr_kind;
   assign rsp_addr_length     = result_ff.addr_length;
   assign rsp_dest_port       = result_ff.dest_port;

endmodule

### design/s5rp_checker.sv
// ----------------------------------------------------------------------------
// s5rp_checker
// Port-level checks for the SOCKS5 request parser, bound to the top level.
// ----------------------------------------------------------------------------
module s5rp_checker
   import s5rp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_addr_byte_valid,
   input logic [7:0]  rsp_addr_byte,
   input logic [7:0]  rsp_addr_index,
   input logic [1:0]  rsp_addr_kind,
   input logic [7:0]  rsp_addr_length,
   input logic [15:0] rsp_dest_port
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_dest_port) && $stable(rsp_addr_byte))
      else $error("result changed while stalled");

   a_store_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_addr_byte_valid |-> rsp_status == STATUS_MORE
         && rsp_addr_kind != KIND_NONE)
      else $error("address byte echoed outside address phase");

   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_addr_byte_valid |-> rsp_addr_byte == 8'd0
         && rsp_addr_index == 8'd0)
      else $error("address echo not cleared");

   a_ipv4_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_addr_kind == KIND_IPV4 |-> rsp_addr_length == V4_ADDR_BYTES)
      else $error("IPv4 length wrong");

   a_ipv6_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_addr_byte_valid && rsp_addr_kind == KIND_IPV6
         |-> rsp_addr_index < V6_ADDR_BYTES)
      else $error("IPv6 index out of range");

endmodule

bind socks5_request_parser_top s5rp_checker u_s5rp_checker (.*);

### tb/socks5_request_parser_top_test.sv
// ----------------------------------------------------------------------------
// socks5_request_parser_top_test
// Drives SOCKS5 request byte streams into the parser and checks every result
// word against an in-bench model of the parse phases. The stimulus covers the
// three address types and rejected or cut-off requests, under four pacing
// phases on both channels.
// ----------------------------------------------------------------------------
module socks5_request_parser_top_test;
   import s5rp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 750;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [7:0] data;
      logic       restart;
   } stream_word;

   class parse_predictor;
      phase_type              cur_phase;
      kind_type               cur_kind;
      logic [7:0]             cur_length;
      logic [COUNT_WIDTH-1:0] cur_count;
      logic [15:0]            cur_port;
      result_type             expected_words[$];
      int                     fails;
      int                     live_bytes;
      int                     n_done;
      int                     n_error;
      int                     n_addr;
      int                     n_checked;

      function new();
         clear();
         fails = 0;
         live_bytes = 0;
         n_done = 0;
         n_error = 0;
         n_addr = 0;
         n_checked = 0;
      endfunction

      function void clear();
         cur_phase  = PH_VERSION;
         cur_kind   = KIND_NONE;
         cur_length = '0;
         cur_count  = '0;
         cur_port   = '0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void take_byte(logic [7:0] b, logic restart);
         result_type w;
         phase_type  prior;
         logic       dom;
         int         idx;
         if (restart) clear();
         prior = cur_phase;
         w = '0;
         case (cur_phase)
            PH_VERSION: cur_phase = (b == VERSION_BYTE) ? PH_COMMAND : PH_ERROR;
            PH_COMMAND: cur_phase = (b == CMD_CONNECT) ? PH_RSV : PH_ERROR;
            PH_RSV:     cur_phase = (b == RSV_BYTE) ? PH_ATYP : PH_ERROR;
            PH_ATYP: begin
               cur_count = '0;
               if (b == ATYP_IPV4) begin
                  cur_kind = KIND_IPV4;
                  cur_length = V4_ADDR_BYTES;
                  cur_phase = PH_ADDR;
               end else if (b == ATYP_IPV6) begin
                  cur_kind = KIND_IPV6;
                  cur_length = V6_ADDR_BYTES;
                  cur_phase = PH_ADDR;
               end else if (b == ATYP_DOMAIN) begin
                  cur_kind = KIND_DOMAIN;
                  cur_phase = PH_ADDR;
               end else begin
                  cur_phase = PH_ERROR;
               end
            end
            PH_ADDR: begin
               dom = (cur_kind == KIND_DOMAIN);
               if (dom && cur_count == 0) begin
                  cur_length = b;
                  cur_count = COUNT_WIDTH'(1);
                  if (b == 8'd0) cur_phase = PH_ERROR;
               end else begin
                  idx = int'(cur_count) - (dom ? 1 : 0);
                  if (idx >= ADDR_BYTES_DEFAULT) begin
                     cur_phase = PH_ERROR;
                  end else begin
                     w.addr_byte_valid = 1'b1;
                     w.addr_byte = b;
                     w.addr_index = idx[7:0];
                     n_addr++;
                     cur_count = cur_count + 1'b1;
                     if (cur_count == COUNT_WIDTH'(cur_length) + COUNT_WIDTH'(dom)) begin
                        cur_count = '0;
                        cur_phase = PH_PORT;
                     end
                  end
               end
            end
            PH_PORT: begin
               cur_port = {cur_port[7:0], b};
               cur_count = cur_count + 1'b1;
               if (cur_count == PORT_BYTES) begin
                  cur_count = '0;
                  cur_phase = PH_DONE;
               end
            end
            default: ;
         endcase
         if (prior != PH_DONE && prior != PH_ERROR) begin
            live_bytes++;
            if (cur_phase == PH_DONE) n_done++;
            if (cur_phase == PH_ERROR) n_error++;
         end
         w.status = (cur_phase == PH_DONE) ? STATUS_DONE :
                    (cur_phase == PH_ERROR) ? STATUS_ERROR : STATUS_MORE;
         w.addr_kind = cur_kind;
         w.addr_length = cur_length;
         w.dest_port = cur_port;
         expected_words.push_back(w);
      endfunction

      function string word_text(result_type w);
         return $sformatf("status %0d valid %0d byte %h index %0d kind %0d length %0d port %h",
                          w.status, w.addr_byte_valid, w.addr_byte, w.addr_index,
                          w.addr_kind, w.addr_length, w.dest_port);
      endfunction

      function void match_word(result_type got);
         result_type exp;
         logic       bad;
         n_checked++;
         if (expected_words.size() == 0) begin
            fails++;
            if (fails <= MAX_REPORTS)
               $display("ERROR: word %0d arrived with none expected: %s",
                        n_checked, word_text(got));
            return;
         end
         exp = expected_words.pop_front();
         bad = (got.status !== exp.status) ||
               (got.addr_byte_valid !== exp.addr_byte_valid) ||
               (got.addr_byte !== exp.addr_byte) ||
               (got.addr_index !== exp.addr_index) ||
               (got.addr_kind !== exp.addr_kind) ||
               (got.addr_length !== exp.addr_length) ||
               (got.dest_port !== exp.dest_port);
         if (bad) begin
            fails++;
            if (fails <= MAX_REPORTS)
               $display("ERROR: word %0d\n  expected %s\n  actual   %s",
                        n_checked, word_text(exp), word_text(got));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_addr_byte_valid;
   logic [7:0]  rsp_addr_byte;
   logic [7:0]  rsp_addr_index;
   logic [1:0]  rsp_addr_kind;
   logic [7:0]  rsp_addr_length;
   logic [15:0] rsp_dest_port;

   parse_predictor board = new();
   stream_word     burst[$];
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             cycles = 0;

   socks5_request_parser_top #(.ADDR_BYTES(ADDR_BYTES_DEFAULT)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_restart         (req_restart),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_addr_byte_valid (rsp_addr_byte_valid),
      .rsp_addr_byte       (rsp_addr_byte),
      .rsp_addr_index      (rsp_addr_index),
      .rsp_addr_kind       (rsp_addr_kind),
      .rsp_addr_length     (rsp_addr_length),
      .rsp_dest_port       (rsp_dest_port)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = rsp_status;
         got.addr_byte_valid = rsp_addr_byte_valid;
         got.addr_byte = rsp_addr_byte;
         got.addr_index = rsp_addr_index;
         got.addr_kind = kind_type'(rsp_addr_kind);
         got.addr_length = rsp_addr_length;
         got.dest_port = rsp_dest_port;
         board.match_word(got);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_byte(input logic [7:0] d, input logic r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_restart <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_byte(d, r);
   endtask

   task automatic send_burst();
      foreach (burst[i]) send_byte(burst[i].data, burst[i].restart);
      burst.delete();
   endtask

   function automatic void put(input logic [7:0] d, input logic r);
      stream_word w;
      w.data = d;
      w.restart = r;
      burst.push_back(w);
   endfunction

   function automatic void put_good(input int sel, input logic first_restart);
      int dom_len;
      put(VERSION_BYTE, first_restart);
      put(CMD_CONNECT, 1'b0);
      put(RSV_BYTE, 1'b0);
      case (sel)
         0: begin
            put(ATYP_IPV4, 1'b0);
            repeat (4) put(8'($urandom), 1'b0);
         end
         1: begin
            put(ATYP_IPV6, 1'b0);
            repeat (16) put(8'($urandom), 1'b0);
         end
         default: begin
            dom_len = ($urandom_range(99) < 5) ? $urandom_range(200, 255) : $urandom_range(1, 24);
            put(ATYP_DOMAIN, 1'b0);
            put(8'(dom_len), 1'b0);
            repeat (dom_len) put(8'($urandom), 1'b0);
         end
      endcase
      put(8'($urandom), 1'b0);
      put(8'($urandom), 1'b0);
   endfunction

   function automatic void make_request();
      int       pick;
      int       cut;
      logic [7:0] v;
      pick = $urandom_range(99);
      if (pick < 65) begin
         put_good($urandom_range(2), 1'b1);
         if ($urandom_range(99) < 20) repeat ($urandom_range(1, 2)) put(8'($urandom), 1'b0);
      end else if (pick < 70) begin
         put(8'($urandom), 1'b1);
         repeat ($urandom_range(0, 2)) put(8'($urandom), 1'b0);
      end else if (pick < 74) begin
         put(VERSION_BYTE, 1'b1);
         put(8'($urandom), 1'b0);
      end else if (pick < 78) begin
         put(VERSION_BYTE, 1'b1);
         put(CMD_CONNECT, 1'b0);
         put(8'($urandom), 1'b0);
      end else if (pick < 82) begin
         do v = 8'($urandom); while (v == ATYP_IPV4 || v == ATYP_DOMAIN || v == ATYP_IPV6);
         put(VERSION_BYTE, 1'b1);
         put(CMD_CONNECT, 1'b0);
         put(RSV_BYTE, 1'b0);
         put(v, 1'b0);
      end else if (pick < 85) begin
         put(VERSION_BYTE, 1'b1);
         put(CMD_CONNECT, 1'b0);
         put(RSV_BYTE, 1'b0);
         put(ATYP_DOMAIN, 1'b0);
         put(8'd0, 1'b0);
      end else if (pick < 92) begin
         put_good($urandom_range(2), 1'b1);
         cut = $urandom_range(1, burst.size() - 1);
         repeat (cut) void'(burst.pop_back());
      end else if (pick < 96) begin
         put_good($urandom_range(2), 1'b0);
      end else begin
         repeat ($urandom_range(1, 4)) put(8'($urandom), 1'($urandom));
      end
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wrong version, then a byte that must be ignored
      put(8'h04, 1'b1);  put(8'hff, 1'b0);
      // wrong command
      put(VERSION_BYTE, 1'b1);  put(8'h02, 1'b0);
      // nonzero reserved byte
      put(VERSION_BYTE, 1'b1);  put(CMD_CONNECT, 1'b0);  put(8'hff, 1'b0);
      // unknown address type
      put(VERSION_BYTE, 1'b1);  put(CMD_CONNECT, 1'b0);  put(RSV_BYTE, 1'b0);
      put(8'h02, 1'b0);
      // zero-length domain
      put(VERSION_BYTE, 1'b1);  put(CMD_CONNECT, 1'b0);  put(RSV_BYTE, 1'b0);
      put(ATYP_DOMAIN, 1'b0);  put(8'h00, 1'b0);
      // IPv4 with extreme bytes, then a byte after completion
      put(VERSION_BYTE, 1'b1);  put(CMD_CONNECT, 1'b0);  put(RSV_BYTE, 1'b0);
      put(ATYP_IPV4, 1'b0);  put(8'h00, 1'b0);  put(8'hff, 1'b0);
      put(8'h80, 1'b0);  put(8'h7f, 1'b0);  put(8'hff, 1'b0);  put(8'hff, 1'b0);
      put(8'h00, 1'b0);
      send_burst();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         while (board.live_bytes < (p + 1) * ITEM_TARGET / 4) begin
            make_request();
            send_burst();
         end
      end
      req_valid <= 1'b0;

      while (board.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("summary: %0d parsed bytes, %0d requests completed, %0d rejected,",
               board.live_bytes, board.n_done, board.n_error);
      $display("summary: %0d address bytes echoed, %0d result words checked",
               board.n_addr, board.n_checked);
      if (board.fails == 0 && board.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("mismatches: %0d", board.fails);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
